// ===== rtl/fbrc_pkg.sv =====
// Shared types, codes and defaults for the freed-block reuse cache.
package fbrc_pkg;

   localparam int unsigned DefEntries   = 16;
   localparam int unsigned DefAddrWidth = 32;
   localparam int unsigned SizeW        = 32;
   localparam int unsigned DataW        = 32;
   localparam int unsigned StatusW      = 3;

   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree  = 1'b1;

   localparam logic [StatusW-1:0] ST_HIT             = 3'd0;
   localparam logic [StatusW-1:0] ST_MISS            = 3'd1;
   localparam logic [StatusW-1:0] ST_ZERO            = 3'd2;
   localparam logic [StatusW-1:0] ST_STORED          = 3'd3;
   localparam logic [StatusW-1:0] ST_FULL_OR_IGNORED = 3'd4;

   typedef struct packed {
      logic             operation;
      logic [SizeW-1:0] block_size;
      logic [DataW-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [DataW-1:0]   granted_address;
   } rsp_type;

   // table write / clear strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } tbl_ctl_type;

endpackage

// ===== rtl/fbrc_table.sv =====
// Entry table: valid flops plus size and address memories with registered read.
module fbrc_table import fbrc_pkg::*; #(
   parameter int unsigned ENTRIES = DefEntries,
   parameter int unsigned STORE_W = DefAddrWidth,
   parameter int unsigned IDX_W   = $clog2(DefEntries)
) (
   input  logic               clock,
   input  logic               reset,
   input  tbl_ctl_type        ctl,
   input  logic [IDX_W-1:0]   wr_idx,
   input  logic [SizeW-1:0]   wr_size,
   input  logic [STORE_W-1:0] wr_addr,
   input  logic [IDX_W-1:0]   clr_idx,
   input  logic [IDX_W-1:0]   rd_idx,
   output logic [SizeW-1:0]   rd_size,
   output logic [STORE_W-1:0] rd_addr,
   output logic [ENTRIES-1:0] valid_vec
);

   logic [SizeW-1:0]   size_mem [ENTRIES];
   logic [STORE_W-1:0] addr_mem [ENTRIES];
   logic [SizeW-1:0]   rd_size_ff;
   logic [STORE_W-1:0] rd_addr_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_en) begin
         valid_in[clr_idx] = 1'b0;
      end
      if (ctl.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         size_mem[wr_idx] <= wr_size;
         addr_mem[wr_idx] <= wr_addr;
      end
      rd_size_ff <= size_mem[rd_idx];
      rd_addr_ff <= addr_mem[rd_idx];
   end

   assign rd_size   = rd_size_ff;
   assign rd_addr   = rd_addr_ff;
   assign valid_vec = valid_ff;

endmodule

// ===== rtl/fbrc_cmp.sv =====
// Shared size comparator: one subtractor serves both exact and first-fit tests.
module fbrc_cmp import fbrc_pkg::*; (
   input  logic             ent_valid,
   input  logic             exact,
   input  logic [SizeW-1:0] ent_size,
   input  logic [SizeW-1:0] want_size,
   output logic             match
);

   logic [SizeW:0] diff;

   always_comb begin
      diff = {1'b0, ent_size} - {1'b0, want_size};
      if (exact) begin
         match = ent_valid & (diff[SizeW-1:0] == '0) & ~diff[SizeW];
      end else begin
         match = ent_valid & ~diff[SizeW];
      end
   end

endmodule

// ===== rtl/freed_block_reuse_cache_core.sv =====
// Top level: sequencer for the freed-block reuse cache.
//
// Requests arrive on req_ (valid/stall); each transfer is an allocate or a
// free. One result per request leaves on rsp_ (valid/stall) from an output
// register, so a stalled result does not block the next request.
// req_stall is high while a request is being worked on; one request at a
// time is handled, and the next one is taken the cycle after a result
// enters the output register. Allocate: the table is read one entry per
// cycle through a single memory read port and checked by one shared
// comparator, first for an exact size from the start index up, then for a
// first fit from entry 0. Free: valid bits are walked circularly from the
// start index, one per cycle. Zero-size allocates and null or zero-size
// frees go straight to the result without a walk. Reset empties the table
// and clears the start index; no clearing pass. If rsp_stall holds a
// result, the next finished result waits inside until the output register
// frees up.
module freed_block_reuse_cache_core import fbrc_pkg::*; #(
   parameter int unsigned ENTRIES    = DefEntries,
   parameter int unsigned ADDR_WIDTH = DefAddrWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned IdxW   = $clog2(ENTRIES);
   localparam int unsigned StoreW = (ADDR_WIDTH < DataW) ? ADDR_WIDTH : DataW;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_FREE = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              exact_ff, exact_in;
   logic              issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IdxW-1:0]   rd_idx_ff, rd_idx_in;
   logic [IdxW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IdxW-1:0]   start_ff, start_in;
   logic [IdxW-1:0]   count_ff, count_in;
   logic [SizeW-1:0]  size_ff, size_in;
   logic [StoreW-1:0] addr_ff, addr_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   tbl_ctl_type        ctl;
   logic [SizeW-1:0]   rd_size;
   logic [StoreW-1:0]  rd_addr;
   logic [ENTRIES-1:0] valid_vec;
   logic               match;
   logic               out_free;

   fbrc_table #(
      .ENTRIES (ENTRIES),
      .STORE_W (StoreW),
      .IDX_W   (IdxW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_idx    (rd_idx_ff),
      .wr_size   (size_ff),
      .wr_addr   (addr_ff),
      .clr_idx   (cmp_idx_ff),
      .rd_idx    (rd_idx_ff),
      .rd_size   (rd_size),
      .rd_addr   (rd_addr),
      .valid_vec (valid_vec)
   );

   fbrc_cmp u_cmp (
      .ent_valid (valid_vec[cmp_idx_ff]),
      .exact     (exact_ff),
      .ent_size  (rd_size),
      .want_size (size_ff),
      .match     (match)
   );

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      exact_in     = exact_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmp_valid_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_in      = req_data.block_size;
               addr_in      = req_data.block_address[StoreW-1:0];
               rd_idx_in    = start_ff;
               count_in     = '0;
               issue_in     = 1'b1;
               cmp_valid_in = 1'b0;
               exact_in     = 1'b1;
               if (req_data.operation == OpAlloc) begin
                  if (req_data.block_size == '0) begin
                     res_in   = '{status: ST_ZERO, granted_address: '0};
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_data.block_address[StoreW-1:0] == '0 ||
                      req_data.block_size == '0) begin
                     res_in   = '{status: ST_FULL_OR_IGNORED, granted_address: '0};
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            // read issue runs ahead of the compare by the table's read register
            cmp_valid_in = issue_ff;
            cmp_idx_in   = rd_idx_ff;
            if (issue_ff) begin
               if (rd_idx_ff == LastIdx) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (cmp_valid_ff && match) begin
               ctl.clr_en = 1'b1;
               start_in   = cmp_idx_ff;
               res_in     = '{status: ST_HIT, granted_address: DataW'(rd_addr)};
               state_in   = S_DONE;
            end else if (cmp_valid_ff && cmp_idx_ff == LastIdx) begin
               start_in = '0;
               if (exact_ff) begin
                  // exact pass failed: first-fit pass from entry 0
                  exact_in     = 1'b0;
                  rd_idx_in    = '0;
                  issue_in     = 1'b1;
                  cmp_valid_in = 1'b0;
               end else begin
                  res_in   = '{status: ST_MISS, granted_address: '0};
                  state_in = S_DONE;
               end
            end
         end
         S_FREE: begin
            if (!valid_vec[rd_idx_ff]) begin
               ctl.wr_en = 1'b1;
               res_in    = '{status: ST_STORED, granted_address: '0};
               state_in  = S_DONE;
            end else if (count_ff == LastIdx) begin
               res_in   = '{status: ST_FULL_OR_IGNORED, granted_address: '0};
               state_in = S_DONE;
            end else begin
               rd_idx_in = (rd_idx_ff == LastIdx) ? '0 : rd_idx_ff + 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         issue_ff     <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exact_ff    <= exact_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      count_ff    <= count_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
